/* rtl/agd_pkg.sv */
package agd_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int ANGLE_W      = 19;
	localparam int THR_W        = 18;
	localparam int CNT_W        = 8;
	localparam int CH_W         = 4;
	localparam int REQ_W        = 2;
	localparam int MASK_W       = 16;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [THR_W-1:0] THR_RESET     = THR_W'(2560);
	localparam logic [CNT_W-1:0] CONFIRM_RESET = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_START  = 2'd1,
		REQ_STOP   = 2'd2,
		REQ_RSVD   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_PASS,
		OP_START,
		OP_STOP,
		OP_NONE
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 8'd0,
		REG_CONFIRM   = 8'd1,
		REG_ENABLE    = 8'd2,
		REG_SKIP      = 8'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                        op;
		logic [CH_W-1:0]            channel;
		logic signed [ANGLE_W-1:0]  angle;
		logic                       err;
	} job_t;

endpackage

/* rtl/agd_if.sv */
interface agd_smp_if import agd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic [CH_W-1:0]            channel;
	logic signed [ANGLE_W-1:0]  angle_in;
	logic                       sensor_error;

	modport source (output valid, req_type, channel, angle_in, sensor_error, input ready);
	modport sink (input valid, req_type, channel, angle_in, sensor_error, output ready);
endinterface

interface agd_res_if import agd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ANGLE_W-1:0]  angle_out;
	logic                       substituted;
	logic                       jump_fault;
	logic                       streaming;

	modport source (output valid, angle_out, substituted, jump_fault, streaming, input ready);
	modport sink (input valid, angle_out, substituted, jump_fault, streaming, output ready);
endinterface

interface agd_cfg_if import agd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/agd_front.sv */
module agd_front import agd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	agd_smp_if.sink      smp,
	output job_t         job,
	output logic         job_valid,
	input  logic         job_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [CH_W:0] CH_LIM = (CH_W+1)'(CHANNELS);

	job_t                 queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W:0]       count_q;
	logic                 push;
	logic                 pop;
	job_t                 job_in;

	// classify the incoming beat
	always_comb begin
		job_in.channel = smp.channel;
		job_in.angle   = smp.angle_in;
		job_in.err     = smp.sensor_error;
		case (req_t'(smp.req_type))
			REQ_SAMPLE: begin
				job_in.op = ({1'b0, smp.channel} < CH_LIM) ? OP_SAMPLE : OP_PASS;
			end
			REQ_START: job_in.op = OP_START;
			REQ_STOP:  job_in.op = OP_STOP;
			default:   job_in.op = OP_NONE;
		endcase
	end

	assign smp.ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign push      = smp.valid && smp.ready;
	assign job_valid = (count_q != '0);
	assign pop       = job_valid && job_ready;
	assign job       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

/* rtl/agd_back.sv */
module agd_back import agd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  job_t         job,
	input  logic         job_valid,
	output logic         job_ready,
	agd_cfg_if.sink      cfg,
	agd_res_if.source    res
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic signed [ANGLE_W-1:0]  good_angle_q [CHANNELS];
	logic [CHANNELS-1:0]        good_valid_q;
	logic [CNT_W-1:0]           dev_cnt_q [CHANNELS];
	logic                       stream_q;
	logic                       fault_q;

	logic [THR_W-1:0]           thr_q;
	logic [CNT_W-1:0]           confirm_q;
	logic                       enable_q;
	logic [MASK_W-1:0]          skip_q;

	logic                       res_valid_q;
	logic signed [ANGLE_W-1:0]  res_angle_q;
	logic                       res_subst_q;

	logic                       take;
	logic [IDX_W-1:0]           idx;
	logic signed [ANGLE_W-1:0]  cur_good;
	logic [CNT_W-1:0]           cur_cnt;
	logic [CNT_W-1:0]           cnt_inc;
	logic signed [ANGLE_W:0]    diff;
	logic [ANGLE_W:0]           mag;
	logic                       is_jump;
	logic                       detect;

	logic                       fault_d;
	logic                       stream_d;
	logic signed [ANGLE_W-1:0]  angle_d;
	logic                       subst_d;
	logic                       clear_all;
	logic                       wr_good;
	logic                       set_valid;
	logic                       clr_valid;
	logic                       wr_cnt;
	logic [CNT_W-1:0]           cnt_d;

	assign cfg.ready = 1'b1;

	assign job_ready = !res_valid_q || res.ready;
	assign take      = job_valid && job_ready;

	assign idx      = job.channel[IDX_W-1:0];
	assign cur_good = good_angle_q[idx];
	assign cur_cnt  = dev_cnt_q[idx];
	assign cnt_inc  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
	assign diff     = {job.angle[ANGLE_W-1], job.angle} - {cur_good[ANGLE_W-1], cur_good};
	assign mag      = diff[ANGLE_W] ? (ANGLE_W+1)'(0) - diff : diff;
	assign is_jump  = (mag >= {{(ANGLE_W+1-THR_W){1'b0}}, thr_q});
	assign detect   = enable_q && stream_q && good_valid_q[idx] && !skip_q[job.channel];

	always_comb begin
		fault_d   = fault_q;
		stream_d  = stream_q;
		angle_d   = '0;
		subst_d   = 1'b0;
		clear_all = 1'b0;
		wr_good   = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		wr_cnt    = 1'b0;
		cnt_d     = '0;
		case (job.op)
			OP_START: begin
				fault_d   = 1'b0;
				stream_d  = 1'b1;
				clear_all = 1'b1;
			end
			OP_STOP: stream_d = 1'b0;
			OP_PASS: angle_d = job.angle;
			OP_SAMPLE: begin
				angle_d = job.angle;
				if (job.err) begin
					clr_valid = 1'b1;
				end else if (detect) begin
					wr_cnt = 1'b1;
					if (is_jump) begin
						cnt_d = cnt_inc;
						if (cnt_inc >= confirm_q) begin
							fault_d  = 1'b1;
							stream_d = 1'b0;
						end else begin
							angle_d = cur_good;
							subst_d = 1'b1;
						end
					end else begin
						wr_good = 1'b1;
					end
				end else begin
					wr_good   = 1'b1;
					set_valid = 1'b1;
					wr_cnt    = 1'b1;
				end
			end
			default: angle_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_valid_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				dev_cnt_q[i] <= '0;
			end
			stream_q    <= 1'b0;
			fault_q     <= 1'b0;
			res_valid_q <= 1'b0;
			thr_q       <= THR_RESET;
			confirm_q   <= CONFIRM_RESET;
			enable_q    <= 1'b1;
			skip_q      <= '0;
		end else begin
			if (cfg.valid) begin
				case (reg_idx_t'(cfg.index))
					REG_THRESHOLD: thr_q     <= cfg.data[THR_W-1:0];
					REG_CONFIRM:   confirm_q <= cfg.data[CNT_W-1:0];
					REG_ENABLE:    enable_q  <= cfg.data[0];
					REG_SKIP:      skip_q    <= cfg.data[MASK_W-1:0];
					default:       thr_q     <= thr_q;
				endcase
			end
			if (take) begin
				res_valid_q <= 1'b1;
				stream_q    <= stream_d;
				fault_q     <= fault_d;
				if (clear_all) begin
					good_valid_q <= '0;
					for (int i = 0; i < CHANNELS; i++) begin
						dev_cnt_q[i] <= '0;
					end
				end
				if (set_valid) begin
					good_valid_q[idx] <= 1'b1;
				end
				if (clr_valid) begin
					good_valid_q[idx] <= 1'b0;
				end
				if (wr_cnt) begin
					dev_cnt_q[idx] <= cnt_d;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_angle_q <= angle_d;
			res_subst_q <= subst_d;
			if (wr_good) begin
				good_angle_q[idx] <= job.angle;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.angle_out   = res_angle_q;
	assign res.substituted = res_subst_q;
	assign res.jump_fault  = fault_q;
	assign res.streaming   = stream_q;

endmodule

/* rtl/angle_jump_glitch_detector_top.sv */
// Angle jump glitch detector.
// smp: one beat per angle sample or start/stop request (req_type, channel,
//   angle_in, sensor_error). res: one beat per smp beat, in order, carrying
//   angle_out, substituted, and the fault latch and stream mode after it.
// cfg: register writes (index, data), always ready; write only while idle.
// A beat taken on smp is queued, then held in the result register for res.
// Throughput: one beat per cycle while res is not stalled, set by the
//   combinational subtract, compare and counter update on the selected
//   channel's state in the back end. A two-entry queue between the two
//   ends plus the result register let smp keep taking beats while res is
//   stalled until the queue fills; then smp.ready drops until res.ready returns.
// Reset: standby, fault clear, all channel validity bits and counters zero,
//   registers at their reset values; no beats are pending.
module angle_jump_glitch_detector_top import agd_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	agd_smp_if.sink      smp,
	agd_res_if.source    res,
	agd_cfg_if.sink      cfg
);

	job_t job;
	logic job_valid;
	logic job_ready;

	agd_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	agd_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.cfg       (cfg),
		.res       (res)
	);

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
	import agd_pkg::*;

	typedef struct {
		req_t                       req;
		logic [CH_W-1:0]            channel;
		logic signed [ANGLE_W-1:0]  angle;
		logic                       err;
		logic                       hold;
	} beat_t;

	typedef struct {
		logic signed [ANGLE_W-1:0]  angle;
		logic                       subst;
		logic                       fault;
		logic                       strm;
	} screened_t;

	logic clk;
	logic arst_n;

	agd_smp_if smp_if ();
	agd_res_if res_if ();
	agd_cfg_if cfg_if ();

	angle_jump_glitch_detector_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	beat_t       sample_q[$];
	screened_t   screened_q[$];
	screened_t   oldest;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int          fail_count;

	// shadow of the block's registers and channel state
	logic [THR_W-1:0]          thr_reg;
	logic [CNT_W-1:0]          confirm_reg;
	logic                      detect_en;
	logic [MASK_W-1:0]         skip_reg;
	logic signed [ANGLE_W-1:0] last_good[16];
	logic                      good_ok[16];
	logic [CNT_W-1:0]          dev_cnt[16];
	logic                      stream_on;
	logic                      fault_latched;

	int track[16];

	function automatic screened_t screen_beat(input logic [REQ_W-1:0] req,
			input logic [CH_W-1:0] ch, input logic signed [ANGLE_W-1:0] a, input logic err);
		screened_t   r;
		int          d;
		int unsigned dev_mag;
		r.angle = '0;
		r.subst = 1'b0;
		case (req)
			REQ_START: begin
				fault_latched = 1'b0;
				stream_on = 1'b1;
				for (int c = 0; c < 16; c++) begin
					good_ok[c] = 1'b0;
					dev_cnt[c] = '0;
				end
			end
			REQ_STOP: stream_on = 1'b0;
			REQ_SAMPLE: begin
				r.angle = a;
				if (err) begin
					good_ok[ch] = 1'b0;
				end else if (detect_en && stream_on && good_ok[ch] && !skip_reg[ch]) begin
					d = a - last_good[ch];
					dev_mag = (d < 0) ? -d : d;
					if (dev_mag >= thr_reg) begin
						if (dev_cnt[ch] != CNT_MAX)
							dev_cnt[ch] = dev_cnt[ch] + 1'b1;
						if (dev_cnt[ch] >= confirm_reg) begin
							fault_latched = 1'b1;
							stream_on = 1'b0;
						end else begin
							r.angle = last_good[ch];
							r.subst = 1'b1;
						end
					end else begin
						last_good[ch] = a;
						dev_cnt[ch] = '0;
					end
				end else begin
					last_good[ch] = a;
					good_ok[ch] = 1'b1;
					dev_cnt[ch] = '0;
				end
			end
			default: ;
		endcase
		r.fault = fault_latched;
		r.strm = stream_on;
		return r;
	endfunction

	function automatic beat_t make_beat(input req_t req, input int ch, input int a,
			input logic err, input logic hold = 1'b0);
		beat_t b;
		b.req = req;
		b.channel = ch[CH_W-1:0];
		b.angle = a[ANGLE_W-1:0];
		b.err = err;
		b.hold = hold;
		return b;
	endfunction

	function automatic int wrap_angle(input int v);
		logic signed [ANGLE_W-1:0] t;
		t = v[ANGLE_W-1:0];
		return t;
	endfunction

	task automatic note_failure(input string what);
		if (fail_count < 10)
			$display("%t: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val,
			input logic [CFG_DATA_W-1:0] mask);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= (val & mask) | ($urandom & ~mask);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_reg = val[THR_W-1:0];
			REG_CONFIRM:   confirm_reg = val[CNT_W-1:0];
			REG_ENABLE:    detect_en = val[0];
			REG_SKIP:      skip_reg = val[MASK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int thr, input int conf, input int en, input int skip);
		write_reg(REG_THRESHOLD, thr, 32'h0003_ffff);
		write_reg(REG_CONFIRM, conf, 32'h0000_00ff);
		write_reg(REG_ENABLE, en, 32'h0000_0001);
		write_reg(REG_SKIP, skip, 32'h0000_ffff);
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (sample_q.size() != 0 || smp_if.valid || screened_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// mostly plausible motion on a few busy channels, with glitches, real jumps
	// and requests mixed in
	task automatic queue_traffic(input int n);
		int   r, m, ch, a, lim, sgn;
		logic hold;
		sample_q.push_back(make_beat(REQ_START, 0, 0, 1'b0));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			hold = ($urandom_range(0, 149) == 0);
			if (r < 6) begin
				sample_q.push_back(make_beat(
					req_t'((r < 3) ? REQ_START : (r < 5) ? REQ_STOP : REQ_RSVD),
					$urandom_range(0, 15), $urandom, 1'($urandom_range(0, 1)), hold));
			end else begin
				ch = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
				lim = (thr_reg == 0) ? 64 : int'(thr_reg);
				sgn = $urandom_range(0, 1) ? 1 : -1;
				m = $urandom_range(0, 99);
				if (m < 55) begin
					a = wrap_angle(track[ch] + int'($urandom_range(0, lim)) - lim / 2);
					track[ch] = a;
				end else if (m < 75) begin
					a = track[ch] + sgn * (int'(thr_reg) + int'($urandom_range(0, lim)));
				end else if (m < 85) begin
					a = track[ch] + sgn * (int'(thr_reg) - int'($urandom_range(0, 1)));
				end else if (m < 90) begin
					track[ch] = wrap_angle(track[ch] + sgn * (2 * lim + int'($urandom_range(0, 1000))));
					a = track[ch];
				end else begin
					a = $urandom;
				end
				sample_q.push_back(make_beat(REQ_SAMPLE, ch, a, ($urandom_range(0, 15) == 0), hold));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_if.valid        <= 1'b0;
			smp_if.req_type     <= REQ_SAMPLE;
			smp_if.channel      <= '0;
			smp_if.angle_in     <= '0;
			smp_if.sensor_error <= 1'b0;
		end else begin
			if (smp_if.valid && smp_if.ready)
				screened_q.push_back(screen_beat(smp_if.req_type, smp_if.channel,
					smp_if.angle_in, smp_if.sensor_error));
			if (!smp_if.valid || smp_if.ready) begin
				if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct &&
						!(sample_q[0].hold && screened_q.size() != 0)) begin
					smp_if.valid        <= 1'b1;
					smp_if.req_type     <= sample_q[0].req;
					smp_if.channel      <= sample_q[0].channel;
					smp_if.angle_in     <= sample_q[0].angle;
					smp_if.sensor_error <= sample_q[0].err;
					void'(sample_q.pop_front());
				end else begin
					smp_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (screened_q.size() == 0) begin
					note_failure($sformatf("result beat with nothing expected: angle %0d",
						res_if.angle_out));
				end else begin
					oldest = screened_q.pop_front();
					if (res_if.angle_out !== oldest.angle || res_if.substituted !== oldest.subst ||
							res_if.jump_fault !== oldest.fault || res_if.streaming !== oldest.strm)
						note_failure($sformatf(
							"mismatch: exp angle %0d subst %0b fault %0b strm %0b, got %0d %0b %0b %0b",
							oldest.angle, oldest.subst, oldest.fault, oldest.strm,
							res_if.angle_out, res_if.substituted, res_if.jump_fault,
							res_if.streaming));
				end
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		smp_if.valid = 1'b0;
		smp_if.req_type = REQ_SAMPLE;
		smp_if.channel = '0;
		smp_if.angle_in = '0;
		smp_if.sensor_error = 1'b0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_THRESHOLD;
		cfg_if.data = '0;
		fail_count = 0;
		thr_reg = THR_RESET;
		confirm_reg = CONFIRM_RESET;
		detect_en = 1'b1;
		skip_reg = '0;
		stream_on = 1'b0;
		fault_latched = 1'b0;
		for (int c = 0; c < 16; c++) begin
			last_good[c] = '0;
			good_ok[c] = 1'b0;
			dev_cnt[c] = '0;
			track[c] = 0;
		end
		send_gap_pct = 29;
		recv_stall_pct = 50;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		sample_q.push_back(make_beat(REQ_SAMPLE, 0, 196607, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 15, -196608, 1'b0));
		sample_q.push_back(make_beat(REQ_START, 0, 0, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 0, -262144, 1'b1));
		sample_q.push_back(make_beat(REQ_SAMPLE, 0, 100, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 0, 100 + 2560, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 0, 100 + 2559, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 1, 0, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 1, 5000, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 1, 5000, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 1, 5000, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 1, 5000, 1'b0));
		sample_q.push_back(make_beat(REQ_RSVD, 9, 1234, 1'b1));
		sample_q.push_back(make_beat(REQ_START, 0, 0, 1'b0, 1'b1));
		sample_q.push_back(make_beat(REQ_SAMPLE, 15, 262143, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 15, -262144, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 15, 262143, 1'b1));
		sample_q.push_back(make_beat(REQ_SAMPLE, 15, -262144, 1'b0));
		sample_q.push_back(make_beat(REQ_STOP, 0, 0, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 2, -1, 1'b0));
		settle();
		queue_traffic(300);
		settle();

		configure(0, 1, 1, 16'ha5a5);
		queue_traffic(330);
		settle();

		send_gap_pct = 50;
		recv_stall_pct = 29;
		configure(262143, 255, 1, 0);
		// drive one channel's counter all the way to the confirm limit
		sample_q.push_back(make_beat(REQ_START, 0, 0, 1'b0));
		sample_q.push_back(make_beat(REQ_SAMPLE, 2, -200000, 1'b0));
		for (int i = 0; i < 260; i++)
			sample_q.push_back(make_beat(REQ_SAMPLE, 2, 100000, 1'b0));
		queue_traffic(300);
		settle();

		configure(1, 0, 1, 16'h0001);
		queue_traffic(330);
		settle();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		configure(800, 2, 0, 16'hffff);
		queue_traffic(330);
		settle();

		configure($urandom_range(0, 4000), $urandom_range(1, 6), 1, $urandom_range(0, 65535));
		queue_traffic(330);
		settle();

		if (fail_count == 0 && screened_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
rtl/agd_pkg.sv
rtl/agd_if.sv
rtl/agd_front.sv
rtl/agd_back.sv
rtl/angle_jump_glitch_detector_top.sv
sim/tb.sv
